>>> src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  // bits of the scaled result magnitude, found one bit per stage
  localparam int QBits = 15;
  // squared length of the cross product, below 2^68
  localparam int LenW  = 68;
  // 32767^2 * n^2, below 2^96
  localparam int TgtW  = 96;
  // trial value q^2 * len2, below 2^98
  localparam int AccW  = 98;
  // running q * len2, below 2^83
  localparam int RunW  = 83;

endpackage

`default_nettype wire

>>> src/tfn_scale.sv
// ----------------------------------------------------------------------------
// tfn_scale
// Pipelined bit-by-bit search for floor(32767 * n / |n|), one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_scale (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire [tfn_pkg::LenW-1:0]   len2_i,
  input  wire [tfn_pkg::TgtW-1:0]   target_i,
  input  wire                       neg_i,
  input  wire                       zero_i,
  output logic [15:0]               norm_o
);

  localparam int N = tfn_pkg::QBits;

  logic [tfn_pkg::AccW-1:0]  p_q    [1:N];
  logic [tfn_pkg::RunW-1:0]  r_q    [1:N];
  logic [N-1:0]              qv_q   [1:N];
  logic [tfn_pkg::LenW-1:0]  l_q    [1:N];
  logic [tfn_pkg::TgtW-1:0]  t_q    [1:N];
  logic                      neg_q  [1:N];
  logic                      zero_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int B = N - 1 - i;

    logic [tfn_pkg::AccW-1:0] p_in;
    logic [tfn_pkg::RunW-1:0] r_in;
    logic [N-1:0]             q_in;
    logic [tfn_pkg::LenW-1:0] l_in;
    logic [tfn_pkg::TgtW-1:0] t_in;
    logic                     neg_in;
    logic                     zero_in;
    logic [tfn_pkg::AccW-1:0] cand;
    logic                     take;

    if (i == 0) begin : g_first
      assign p_in    = '0;
      assign r_in    = '0;
      assign q_in    = '0;
      assign l_in    = len2_i;
      assign t_in    = target_i;
      assign neg_in  = neg_i;
      assign zero_in = zero_i;
    end else begin : g_next
      assign p_in    = p_q[i];
      assign r_in    = r_q[i];
      assign q_in    = qv_q[i];
      assign l_in    = l_q[i];
      assign t_in    = t_q[i];
      assign neg_in  = neg_q[i];
      assign zero_in = zero_q[i];
    end

    // (q + 2^B)^2 * L = q^2*L + 2^(B+1)*q*L + 2^(2B)*L
    assign cand = p_in + (tfn_pkg::AccW'(r_in) << (B + 1))
                       + (tfn_pkg::AccW'(l_in) << (2 * B));
    // negative components round toward minus infinity: strict compare
    assign take = neg_in ? (cand < tfn_pkg::AccW'(t_in))
                         : (cand <= tfn_pkg::AccW'(t_in));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[i+1]    <= take ? cand : p_in;
        r_q[i+1]    <= take ? r_in + (tfn_pkg::RunW'(l_in) << B) : r_in;
        qv_q[i+1]   <= take ? (q_in | (N'(1) << B)) : q_in;
        l_q[i+1]    <= l_in;
        t_q[i+1]    <= t_in;
        neg_q[i+1]  <= neg_in;
        zero_q[i+1] <= zero_in;
      end
    end
  end

  always_comb begin
    if (zero_q[N]) begin
      norm_o = '0;
    end else if (neg_q[N]) begin
      norm_o = ~{1'b0, qv_q[N]};
    end else begin
      norm_o = {1'b0, qv_q[N]};
    end
  end

endmodule

`default_nettype wire

>>> src/triangle_face_normal_snorm16.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_snorm16
// Unit face normal of a triangle as signed 16-bit normalized components.
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields (low bit first)
//  s_axis   in         a_x a_y a_z b_x b_y b_z c_x c_y c_z, 16 bits each
//  m_axis   out        norm_x norm_y norm_z, 16 bits each
//
// One word accepted per clock while not held, one result word per input word.
// Path from accept to the output register: 7 arithmetic stages, 15 search
// stages of one result bit each, then the output register.
// All stages share one advance enable: the pipeline moves when the output
// register is empty or being taken, and holds as a whole otherwise.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_snorm16 (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire  [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // norm_x, norm_y, norm_z
  output logic [47:0]  m_axis_tdata_o
);

  localparam int Depth = 7 + tfn_pkg::QBits;

  logic             en;
  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  logic [47:0]      out_q;

  // advance everything when the output slot frees up
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // --- stage 1: edge vectors u = c - b, v = a - b --------------------------
  logic signed [16:0] u_q [3];
  logic signed [16:0] v_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= $signed({s_axis_tdata_i[96 + 16*k + 15], s_axis_tdata_i[96 + 16*k +: 16]})
                - $signed({s_axis_tdata_i[48 + 16*k + 15], s_axis_tdata_i[48 + 16*k +: 16]});
        v_q[k] <= $signed({s_axis_tdata_i[16*k + 15], s_axis_tdata_i[16*k +: 16]})
                - $signed({s_axis_tdata_i[48 + 16*k + 15], s_axis_tdata_i[48 + 16*k +: 16]});
      end
    end
  end

  // --- stage 2: the six cross products -------------------------------------
  logic signed [33:0] pa_q [3];
  logic signed [33:0] pb_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= u_q[1] * v_q[2];
      pb_q[0] <= u_q[2] * v_q[1];
      pa_q[1] <= u_q[2] * v_q[0];
      pb_q[1] <= u_q[0] * v_q[2];
      pa_q[2] <= u_q[0] * v_q[1];
      pb_q[2] <= u_q[1] * v_q[0];
    end
  end

  // --- stage 3: normal components as sign and magnitude --------------------
  logic [32:0] mag_q [3];
  logic [2:0]  neg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [33:0] n;
        n = pa_q[k] - pb_q[k];
        neg3_q[k] <= n[33];
        mag_q[k]  <= n[33] ? 33'(-n) : 33'(n);
      end
    end
  end

  // --- stage 4: partial products of the squares ----------------------------
  logic [31:0] hh_q [3];
  logic [32:0] hl_q [3];
  logic [33:0] ll_q [3];
  logic [2:0]  neg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= mag_q[k][32:17] * mag_q[k][32:17];
        hl_q[k] <= 33'(mag_q[k][32:17]) * 33'(mag_q[k][16:0]);
        ll_q[k] <= 34'(mag_q[k][16:0]) * 34'(mag_q[k][16:0]);
      end
      neg4_q <= neg3_q;
    end
  end

  // --- stage 5: squares n_k^2 ----------------------------------------------
  logic [65:0] sq_q [3];
  logic [2:0]  neg5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (66'(hh_q[k]) << 34) + (66'(hl_q[k]) << 18) + 66'(ll_q[k]);
      end
      neg5_q <= neg4_q;
    end
  end

  // --- stage 6: squared length, first factor of 32767 ----------------------
  logic [tfn_pkg::LenW-1:0] len6_q;
  logic [80:0]              m1_q [3];
  logic [2:0]               neg6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len6_q <= tfn_pkg::LenW'(sq_q[0]) + tfn_pkg::LenW'(sq_q[1])
              + tfn_pkg::LenW'(sq_q[2]);
      for (int k = 0; k < 3; k++) begin
        m1_q[k] <= (81'(sq_q[k]) << 15) - 81'(sq_q[k]);
      end
      neg6_q <= neg5_q;
    end
  end

  // --- stage 7: targets 32767^2 * n_k^2, degenerate flag -------------------
  logic [tfn_pkg::LenW-1:0] len7_q;
  logic [tfn_pkg::TgtW-1:0] tgt_q [3];
  logic [2:0]               neg7_q;
  logic                     zero7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len7_q  <= len6_q;
      zero7_q <= (len6_q == '0);
      for (int k = 0; k < 3; k++) begin
        tgt_q[k] <= (tfn_pkg::TgtW'(m1_q[k]) << 15) - tfn_pkg::TgtW'(m1_q[k]);
      end
      neg7_q <= neg6_q;
    end
  end

  // --- stages 8..22: one result bit per stage, per component ---------------
  logic [15:0] norm [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    tfn_scale u_scale (
      .clk_i    (clk_i),
      .en_i     (en),
      .len2_i   (len7_q),
      .target_i (tgt_q[k]),
      .neg_i    (neg7_q[k]),
      .zero_i   (zero7_q),
      .norm_o   (norm[k])
    );
  end

  // --- valid bits and output register --------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Depth-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {norm[2], norm[1], norm[0]};
    end
  end

  // --- checks ---------------------------------------------------------------
  // a held result blocks intake
  a_stall_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("intake open while result stalled");

  // an accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted word lost at first stage");

  // normalized components never reach -32768
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q[15:0] != 16'h8000) && (out_q[31:16] != 16'h8000)
                  && (out_q[47:32] != 16'h8000))
    else $error("normal component out of range");

endmodule

`default_nettype wire
